// ===== design/bab_pkg.sv =====
// bab_pkg: shared types and constants of the bulge arc bounding box block
// segment and box transaction structs, register codes and pipeline sizes
// no dependencies
`timescale 1ns / 1ps

package bab_pkg;

	localparam int COORD_W    = 32;
	localparam int BULGE_W    = 16;
	localparam int BULGE_FRAC = 14;
	localparam int REG_W      = 15;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [REG_W-1:0] LINE_THR_RST = 15'd1;
	localparam logic [REG_W-1:0] SEMI_THR_RST = 15'd16380;

	// register select is the word address bit
	localparam logic REG_LINE_THR = 1'b0;
	localparam logic REG_SEMI_THR = 1'b1;

	// square root: 66-bit radicand, 33 root digits, three digits per stage, one rounding stage
	localparam int SQ_IN_W  = 66;
	localparam int SQ_OUT_W = 33;
	localparam int SQ_PER   = 3;
	localparam int SQ_ST    = SQ_OUT_W / SQ_PER;
	localparam int SQ_LAT   = SQ_ST + 1;

	// divider: 52-bit dividend, 16-bit divisor, four quotient bits per stage
	localparam int DV_NW  = 52;
	localparam int DV_DW  = 16;
	localparam int DV_PER = 4;
	localparam int DV_ST  = DV_NW / DV_PER;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [BULGE_W-1:0] bulge;
	} seg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic                      is_arc;
		logic                      saturated;
	} box_t;

endpackage

// ===== design/bab_sqrt.sv =====
// bab_sqrt: pipelined integer square root, rounded to nearest with ties upward
// digit-by-digit restoring method, several digits per register stage
// depends on bab_pkg
`timescale 1ns / 1ps

module bab_sqrt (
	input  logic                             clk,
	input  logic                             en,
	input  logic [bab_pkg::SQ_IN_W-1:0]      rad,
	output logic [bab_pkg::SQ_OUT_W-1:0]     root
);

	localparam int RW = bab_pkg::SQ_OUT_W + 3;
	localparam int IW = bab_pkg::SQ_IN_W;
	localparam int OW = bab_pkg::SQ_OUT_W;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [OW-1:0] acc;
		logic [IW-1:0] rest;
	} sq_t;

	function automatic sq_t sq_steps(sq_t x);
		sq_t           y;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		y = x;
		for (int i = 0; i < bab_pkg::SQ_PER; i++) begin
			cur   = {y.rem[RW-3:0], y.rest[IW-1 -: 2]};
			trial = {1'b0, y.acc, 2'b01};
			if (cur >= trial) begin
				y.rem = cur - trial;
				y.acc = {y.acc[OW-2:0], 1'b1};
			end else begin
				y.rem = cur;
				y.acc = {y.acc[OW-2:0], 1'b0};
			end
			y.rest = {y.rest[IW-3:0], 2'b00};
		end
		return y;
	endfunction

	sq_t           stg_s [bab_pkg::SQ_ST];
	sq_t           init;
	logic [OW-1:0] rnd_s;

	always_comb begin
		init.rem  = '0;
		init.acc  = '0;
		init.rest = rad;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= sq_steps(init);
			for (int k = 1; k < bab_pkg::SQ_ST; k++) begin
				stg_s[k] <= sq_steps(stg_s[k-1]);
			end
			// remainder above the root means the true root lies past the half point
			if (stg_s[bab_pkg::SQ_ST-1].rem > {3'b000, stg_s[bab_pkg::SQ_ST-1].acc})
				rnd_s <= stg_s[bab_pkg::SQ_ST-1].acc + OW'(1);
			else
				rnd_s <= stg_s[bab_pkg::SQ_ST-1].acc;
		end
	end

	assign root = rnd_s;

endmodule

// ===== design/bab_div.sv =====
// bab_div: pipelined unsigned restoring divider, quotient truncated
// a few quotient bits per register stage, divisor travels with the dividend
// depends on bab_pkg
`timescale 1ns / 1ps

module bab_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [bab_pkg::DV_NW-1:0]     num,
	input  logic [bab_pkg::DV_DW-1:0]     den,
	output logic [bab_pkg::DV_NW-1:0]     quo
);

	localparam int NW = bab_pkg::DV_NW;
	localparam int DW = bab_pkg::DV_DW;

	typedef struct packed {
		logic [DW:0]   rem;
		logic [NW-1:0] q;
		logic [NW-1:0] rest;
		logic [DW-1:0] d;
	} dv_t;

	function automatic dv_t dv_steps(dv_t x);
		dv_t         y;
		logic [DW:0] cur;
		y = x;
		for (int i = 0; i < bab_pkg::DV_PER; i++) begin
			cur = {y.rem[DW-1:0], y.rest[NW-1]};
			if (cur >= {1'b0, y.d}) begin
				y.rem = cur - {1'b0, y.d};
				y.q   = {y.q[NW-2:0], 1'b1};
			end else begin
				y.rem = cur;
				y.q   = {y.q[NW-2:0], 1'b0};
			end
			y.rest = {y.rest[NW-2:0], 1'b0};
		end
		return y;
	endfunction

	dv_t stg_s [bab_pkg::DV_ST];
	dv_t init;

	always_comb begin
		init.rem  = '0;
		init.q    = '0;
		init.rest = num;
		init.d    = den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= dv_steps(init);
			for (int k = 1; k < bab_pkg::DV_ST; k++) begin
				stg_s[k] <= dv_steps(stg_s[k-1]);
			end
		end
	end

	assign quo = stg_s[bab_pkg::DV_ST-1].q;

endmodule

// ===== design/bulge_arc_bounding_box.sv =====
// bulge_arc_bounding_box: axis-aligned box of a polyline segment with bulge
// top level: front-end products, square root and divider pipelines, side test, clamp
// depends on bab_pkg, bab_sqrt, bab_div
//
//   channel   direction  handshake              payload
//   seg       in         seg_valid / seg_stall  bab_pkg::seg_t
//   box       out        box_valid / box_stall  bab_pkg::box_t
//   apb       in/out     psel / penable         paddr, pwdata, prdata (two registers)
//
// one segment per cycle while the pipeline is not held
// most of the pipeline depth lies in the 12-stage square root and the 13-stage divider
// while the output holds an unaccepted box under stall the whole pipeline holds
// arst_n clears the valid bits and loads the threshold registers
`timescale 1ns / 1ps

module bulge_arc_bounding_box (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          seg_valid,
	output logic                          seg_stall,
	input  bab_pkg::seg_t                 seg,
	output logic                          box_valid,
	input  logic                          box_stall,
	output bab_pkg::box_t                 box,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bab_pkg::ADDR_W-1:0]    paddr,
	input  logic [bab_pkg::DATA_W-1:0]    pwdata,
	output logic [bab_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int SQL = bab_pkg::SQ_LAT;
	localparam int DVL = bab_pkg::DV_ST;
	localparam int NW  = bab_pkg::DV_NW;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] mnx;
		logic signed [31:0] mxx;
		logic signed [31:0] mny;
		logic signed [31:0] mxy;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic               arc;
		logic               semi;
		logic               tneg;
		logic               negx;
		logic               negy;
		logic [15:0]        at;
		logic [30:0]        tsq;
		logic [30:0]        k;
		logic [30:0]        a;
		logic signed [31:0] b;
		logic [63:0]        dxx;
		logic [63:0]        dyy;
		logic signed [64:0] pxa;
		logic signed [64:0] pyb;
		logic signed [64:0] pya;
		logic signed [64:0] pxb;
		logic [64:0]        ss;
		logic signed [65:0] nx;
		logic signed [65:0] ny;
	} ctx_t;

	typedef struct packed {
		logic signed [51:0] cxp;
		logic signed [51:0] cxm;
		logic signed [51:0] cx0;
		logic signed [51:0] cyp;
		logic signed [51:0] cym;
		logic signed [51:0] cy0;
	} cand_t;

	// configuration registers
	logic [bab_pkg::REG_W-1:0] line_thr_q;
	logic [bab_pkg::REG_W-1:0] semi_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_thr_q <= bab_pkg::LINE_THR_RST;
			semi_thr_q <= bab_pkg::SEMI_THR_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				bab_pkg::REG_LINE_THR: line_thr_q <= pwdata[bab_pkg::REG_W-1:0];
				bab_pkg::REG_SEMI_THR: semi_thr_q <= pwdata[bab_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bab_pkg::REG_LINE_THR: prdata = {17'd0, line_thr_q};
			bab_pkg::REG_SEMI_THR: prdata = {17'd0, semi_thr_q};
			default:               prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// pipeline advance
	logic en;
	assign en        = !box_valid || !box_stall;
	assign seg_stall = !en;

	logic           v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [SQL-1:0] v_sq;
	logic [DVL-1:0] v_dv;
	logic           v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0;
			v_sq  <= '0;   v_dv  <= '0;
			v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0;
		end else if (en) begin
			v_s1  <= seg_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_sq  <= {v_sq[SQL-2:0], v_s5};
			v_s6  <= v_sq[SQL-1];
			v_s7  <= v_s6;
			v_dv  <= {v_dv[DVL-2:0], v_s7};
			v_s8  <= v_dv[DVL-1];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	assign box_valid = v_s14;

	// front end: differences, bulge terms, products
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	ctx_t ctx_sq_s [SQL];
	ctx_t ctx_dv_s [DVL];
	ctx_t ctx_s8, ctx_s9, ctx_s10, ctx_s11, ctx_s12, ctx_s13;
	ctx_t c1_n, c2_n, c3_n, c4_n, c5_n, c6_n;

	always_comb begin
		c1_n     = '0;
		c1_n.sx  = seg.start_x;
		c1_n.sy  = seg.start_y;
		c1_n.dx  = 33'(seg.end_x) - 33'(seg.start_x);
		c1_n.dy  = 33'(seg.end_y) - 33'(seg.start_y);
		c1_n.mnx = (seg.start_x < seg.end_x) ? seg.start_x : seg.end_x;
		c1_n.mxx = (seg.start_x < seg.end_x) ? seg.end_x : seg.start_x;
		c1_n.mny = (seg.start_y < seg.end_y) ? seg.start_y : seg.end_y;
		c1_n.mxy = (seg.start_y < seg.end_y) ? seg.end_y : seg.start_y;
		c1_n.at  = seg.bulge[15] ? 16'(-seg.bulge) : seg.bulge;
		c1_n.tneg = seg.bulge[15];
		c1_n.semi = $signed(seg.bulge) > $signed({1'b0, semi_thr_q});
		c1_n.arc  = (c1_n.at != 16'd0) && (c1_n.at >= {1'b0, line_thr_q});
	end

	logic [31:0] tsq_w;
	always_comb begin
		c2_n     = ctx_s1;
		tsq_w    = ctx_s1.at * ctx_s1.at;
		c2_n.tsq = tsq_w[30:0];
	end

	logic signed [31:0] b0_w;
	logic signed [65:0] sqx_w, sqy_w;
	always_comb begin
		c3_n   = ctx_s2;
		// with a negative bulge the numerator sign flips, folded into a and b
		c3_n.a = {ctx_s2.at[15:0], 15'd0};
		b0_w   = 32'sd268435456 - $signed({1'b0, ctx_s2.tsq});
		c3_n.b = ctx_s2.tneg ? -b0_w : b0_w;
		c3_n.k = 31'd268435456 + ctx_s2.tsq;
		sqx_w  = ctx_s2.dx * ctx_s2.dx;
		sqy_w  = ctx_s2.dy * ctx_s2.dy;
		c3_n.dxx = sqx_w[63:0];
		c3_n.dyy = sqy_w[63:0];
	end

	always_comb begin
		c4_n     = ctx_s3;
		c4_n.pxa = ctx_s3.dx * $signed({1'b0, ctx_s3.a});
		c4_n.pya = ctx_s3.dy * $signed({1'b0, ctx_s3.a});
		c4_n.pyb = ctx_s3.dy * ctx_s3.b;
		c4_n.pxb = ctx_s3.dx * ctx_s3.b;
		c4_n.ss  = {1'b0, ctx_s3.dxx} + {1'b0, ctx_s3.dyy};
	end

	always_comb begin
		c5_n    = ctx_s4;
		c5_n.nx = 66'(ctx_s4.pxa) - 66'(ctx_s4.pyb);
		c5_n.ny = 66'(ctx_s4.pya) + 66'(ctx_s4.pxb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= c1_n;
			ctx_s2 <= c2_n;
			ctx_s3 <= c3_n;
			ctx_s4 <= c4_n;
			ctx_s5 <= c5_n;
			ctx_sq_s[0] <= ctx_s5;
			for (int k = 1; k < SQL; k++) ctx_sq_s[k] <= ctx_sq_s[k-1];
		end
	end

	// chord length
	logic [bab_pkg::SQ_OUT_W-1:0] len_w;

	bab_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, ctx_s5.ss}),
		.root (len_w)
	);

	// divider operand preparation
	logic [63:0] prod_s6;
	logic [65:0] absx_s6, absy_s6;
	logic [63:0] prod_w;

	always_comb begin
		c6_n      = ctx_sq_s[SQL-1];
		prod_w    = len_w * ctx_sq_s[SQL-1].k;
		c6_n.negx = ctx_sq_s[SQL-1].semi ? ctx_sq_s[SQL-1].dx[32] : ctx_sq_s[SQL-1].nx[65];
		c6_n.negy = ctx_sq_s[SQL-1].semi ? ctx_sq_s[SQL-1].dy[32] : ctx_sq_s[SQL-1].ny[65];
	end

	logic [NW-1:0]  nr_s7, nx_s7, ny_s7;
	logic [15:0]    dr_s7, dc_s7;
	logic [65:0]    sumr_w;
	logic [66:0]    sumx_w, sumy_w;
	logic [32:0]    adx_w, ady_w;
	logic [33:0]    hx_w, hy_w;

	always_comb begin
		// half-up rounding: (2n + den) / (2 den), with den = |t| << 16
		sumr_w = {1'b0, prod_s6, 1'b0} + {34'd0, ctx_s6.at, 16'd0};
		sumx_w = {absx_s6, 1'b0} + {35'd0, ctx_s6.at, 16'd0};
		sumy_w = {absy_s6, 1'b0} + {35'd0, ctx_s6.at, 16'd0};
		adx_w  = ctx_s6.dx[32] ? 33'(-ctx_s6.dx) : ctx_s6.dx;
		ady_w  = ctx_s6.dy[32] ? 33'(-ctx_s6.dy) : ctx_s6.dy;
		hx_w   = {1'b0, adx_w} + 34'd1;
		hy_w   = {1'b0, ady_w} + 34'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s6  <= c6_n;
			prod_s6 <= prod_w;
			absx_s6 <= ctx_sq_s[SQL-1].nx[65] ? 66'(-ctx_sq_s[SQL-1].nx) : ctx_sq_s[SQL-1].nx;
			absy_s6 <= ctx_sq_s[SQL-1].ny[65] ? 66'(-ctx_sq_s[SQL-1].ny) : ctx_sq_s[SQL-1].ny;
			ctx_s7  <= ctx_s6;
			nr_s7   <= {3'd0, sumr_w[65:17]};
			dr_s7   <= ctx_s6.at;
			if (ctx_s6.semi) begin
				// centre at the chord midpoint
				nx_s7 <= {19'd0, hx_w[33:1]};
				ny_s7 <= {19'd0, hy_w[33:1]};
				dc_s7 <= 16'd1;
			end else begin
				nx_s7 <= {2'd0, sumx_w[66:17]};
				ny_s7 <= {2'd0, sumy_w[66:17]};
				dc_s7 <= ctx_s6.at;
			end
			ctx_dv_s[0] <= ctx_s7;
			for (int k = 1; k < DVL; k++) ctx_dv_s[k] <= ctx_dv_s[k-1];
		end
	end

	logic [NW-1:0] qr_w, qx_w, qy_w;

	bab_div u_div_r (.clk(clk), .en(en), .num(nr_s7), .den(dr_s7), .quo(qr_w));
	bab_div u_div_x (.clk(clk), .en(en), .num(nx_s7), .den(dc_s7), .quo(qx_w));
	bab_div u_div_y (.clk(clk), .en(en), .num(ny_s7), .den(dc_s7), .quo(qy_w));

	// back end: centre, side test, box
	logic signed [49:0] rcx_s8, rcy_s8, rr_s8;
	logic signed [58:0] plo_s9 [4];
	logic signed [57:0] phi_s9 [4];
	cand_t              cand_s9, cand_s10, cand_s11, cand_s12;
	logic signed [83:0] prd_s10 [4];
	logic signed [84:0] cr_s11;
	logic signed [83:0] dxr_s11, dyr_s11;
	logic [3:0]         keep_s12;
	logic signed [51:0] mnx_s13, mxx_s13, mny_s13, mxy_s13;
	bab_pkg::box_t      box_s14;

	logic signed [49:0] px_w [4];
	logic signed [32:0] pa_w [4];
	cand_t              cand_w;

	always_comb begin
		// operand pairs: dx*rcy, dy*rcx, dx*r, dy*r
		pa_w[0] = ctx_s8.dx; px_w[0] = rcy_s8;
		pa_w[1] = ctx_s8.dy; px_w[1] = rcx_s8;
		pa_w[2] = ctx_s8.dx; px_w[2] = rr_s8;
		pa_w[3] = ctx_s8.dy; px_w[3] = rr_s8;
		cand_w.cx0 = 52'(ctx_s8.sx) + 52'(rcx_s8);
		cand_w.cxp = 52'(ctx_s8.sx) + 52'(rcx_s8) + 52'(rr_s8);
		cand_w.cxm = 52'(ctx_s8.sx) + 52'(rcx_s8) - 52'(rr_s8);
		cand_w.cy0 = 52'(ctx_s8.sy) + 52'(rcy_s8);
		cand_w.cyp = 52'(ctx_s8.sy) + 52'(rcy_s8) + 52'(rr_s8);
		cand_w.cym = 52'(ctx_s8.sy) + 52'(rcy_s8) - 52'(rr_s8);
	end

	logic signed [84:0] t0_w, t1_w, t2_w, t3_w;
	logic               cneg_w;

	always_comb begin
		t0_w   = cr_s11 - 85'(dyr_s11);
		t1_w   = cr_s11 + 85'(dxr_s11);
		t2_w   = cr_s11 + 85'(dyr_s11);
		t3_w   = cr_s11 - 85'(dxr_s11);
		cneg_w = cr_s11[84];
	end

	logic signed [51:0] mnx_w, mxx_w, mny_w, mxy_w;

	always_comb begin
		mnx_w = 52'(ctx_s12.mnx);
		mxx_w = 52'(ctx_s12.mxx);
		mny_w = 52'(ctx_s12.mny);
		mxy_w = 52'(ctx_s12.mxy);
		if (keep_s12[0]) begin
			if (cand_s12.cxp < mnx_w) mnx_w = cand_s12.cxp;
			if (cand_s12.cxp > mxx_w) mxx_w = cand_s12.cxp;
			if (cand_s12.cy0 < mny_w) mny_w = cand_s12.cy0;
			if (cand_s12.cy0 > mxy_w) mxy_w = cand_s12.cy0;
		end
		if (keep_s12[1]) begin
			if (cand_s12.cx0 < mnx_w) mnx_w = cand_s12.cx0;
			if (cand_s12.cx0 > mxx_w) mxx_w = cand_s12.cx0;
			if (cand_s12.cyp < mny_w) mny_w = cand_s12.cyp;
			if (cand_s12.cyp > mxy_w) mxy_w = cand_s12.cyp;
		end
		if (keep_s12[2]) begin
			if (cand_s12.cxm < mnx_w) mnx_w = cand_s12.cxm;
			if (cand_s12.cxm > mxx_w) mxx_w = cand_s12.cxm;
			if (cand_s12.cy0 < mny_w) mny_w = cand_s12.cy0;
			if (cand_s12.cy0 > mxy_w) mxy_w = cand_s12.cy0;
		end
		if (keep_s12[3]) begin
			if (cand_s12.cx0 < mnx_w) mnx_w = cand_s12.cx0;
			if (cand_s12.cx0 > mxx_w) mxx_w = cand_s12.cx0;
			if (cand_s12.cym < mny_w) mny_w = cand_s12.cym;
			if (cand_s12.cym > mxy_w) mxy_w = cand_s12.cym;
		end
	end

	// saturating narrow to a coordinate, flag in the top bit
	function automatic logic [32:0] clamp_c(input logic signed [51:0] v);
		logic [32:0] res;
		if (v > 52'sd2147483647)
			res = {1'b1, 32'h7FFF_FFFF};
		else if (v < -52'sd2147483648)
			res = {1'b1, 32'h8000_0000};
		else
			res = {1'b0, v[31:0]};
		return res;
	endfunction

	logic [32:0] kmnx_w, kmny_w, kmxx_w, kmxy_w;

	always_comb begin
		kmnx_w = clamp_c(mnx_s13);
		kmny_w = clamp_c(mny_s13);
		kmxx_w = clamp_c(mxx_s13);
		kmxy_w = clamp_c(mxy_s13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s8 <= ctx_dv_s[DVL-1];
			rcx_s8 <= ctx_dv_s[DVL-1].negx ? -$signed({1'b0, qx_w[48:0]})
			                               :  $signed({1'b0, qx_w[48:0]});
			rcy_s8 <= ctx_dv_s[DVL-1].negy ? -$signed({1'b0, qy_w[48:0]})
			                               :  $signed({1'b0, qy_w[48:0]});
			rr_s8  <= $signed({1'b0, qr_w[48:0]});

			ctx_s9  <= ctx_s8;
			cand_s9 <= cand_w;
			// 33 x 50 products split at bit 25
			for (int j = 0; j < 4; j++) begin
				plo_s9[j] <= pa_w[j] * $signed({1'b0, px_w[j][24:0]});
				phi_s9[j] <= pa_w[j] * $signed(px_w[j][49:25]);
			end

			ctx_s10  <= ctx_s9;
			cand_s10 <= cand_s9;
			for (int j = 0; j < 4; j++) begin
				prd_s10[j] <= (84'(phi_s9[j]) <<< 25) + 84'(plo_s9[j]);
			end

			ctx_s11  <= ctx_s10;
			cand_s11 <= cand_s10;
			cr_s11   <= 85'(prd_s10[0]) - 85'(prd_s10[1]);
			dxr_s11  <= prd_s10[2];
			dyr_s11  <= prd_s10[3];

			// an extreme is kept when it lies across the chord from the centre
			ctx_s12     <= ctx_s11;
			cand_s12    <= cand_s11;
			keep_s12[0] <= ctx_s11.arc && (t0_w[84] != cneg_w);
			keep_s12[1] <= ctx_s11.arc && (t1_w[84] != cneg_w);
			keep_s12[2] <= ctx_s11.arc && (t2_w[84] != cneg_w);
			keep_s12[3] <= ctx_s11.arc && (t3_w[84] != cneg_w);

			ctx_s13 <= ctx_s12;
			mnx_s13 <= mnx_w;
			mxx_s13 <= mxx_w;
			mny_s13 <= mny_w;
			mxy_s13 <= mxy_w;

			box_s14.min_x     <= kmnx_w[31:0];
			box_s14.min_y     <= kmny_w[31:0];
			box_s14.max_x     <= kmxx_w[31:0];
			box_s14.max_y     <= kmxy_w[31:0];
			box_s14.is_arc    <= ctx_s13.arc;
			box_s14.saturated <= kmnx_w[32] | kmny_w[32] | kmxx_w[32] | kmxy_w[32];
		end
	end

	assign box = box_s14;

	// checks
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_stall |=> v_s1)
		else $error("accepted segment did not enter the pipeline");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> ($signed(box.min_x) <= $signed(box.max_x)) &&
		              ($signed(box.min_y) <= $signed(box.max_y)))
		else $error("box corners out of order");

	a_line_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box.is_arc |-> !box.saturated)
		else $error("straight segment reported saturation");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_stall |=> box_valid && $stable(v_s13))
		else $error("pipeline moved while the output was held");

endmodule

// ===== sim/bab_box_checker.sv =====
// bab_box_checker: watches the segment, box and register channels of the bounding box block
// predicts each box from the accepted segment and the thresholds written so far
// depends on bab_pkg
`timescale 1ns / 1ps

module bab_box_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       seg_valid,
	input  logic                       seg_stall,
	input  bab_pkg::seg_t              seg,
	input  logic                       box_valid,
	input  logic                       box_stall,
	input  bab_pkg::box_t              box,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [bab_pkg::ADDR_W-1:0] paddr,
	input  logic [bab_pkg::DATA_W-1:0] pwdata,
	output int                         mismatches,
	output int                         boxes_owed
);
	import bab_pkg::*;

	logic [REG_W-1:0] line_thr;
	logic [REG_W-1:0] semi_thr;
	box_t             box_q[$];

	function automatic logic signed [127:0] mul_wide(longint a, longint b);
		logic signed [127:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	function automatic logic signed [127:0] cross_wide(longint ax, longint ay, longint bx,
		longint by);
		return mul_wide(ax, by) - mul_wide(ay, bx);
	endfunction

	// rounds half away from zero, magnitude capped at 2^61
	function automatic longint div_round(logic signed [127:0] num, longint unsigned den);
		logic [127:0] m, q, rm, dd;
		logic         neg;
		neg = num[127];
		m = neg ? -num : num;
		dd = den;
		q = m / dd;
		rm = m % dd;
		if (rm >= dd - rm)
			q = q + 1;
		if (q > (128'd1 << 61))
			q = 128'd1 << 61;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// square root rounded to nearest, ties upward
	function automatic longint unsigned root_round(logic [127:0] s);
		longint unsigned res;
		logic [127:0]    wc;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			wc = {64'd0, res | (64'd1 << b)};
			if (wc * wc <= s)
				res = wc[63:0];
		end
		wc = {64'd0, res};
		if (s - wc * wc > wc)
			res = res + 1;
		return res;
	endfunction

	function automatic box_t predict_box(seg_t s, logic [REG_W-1:0] lthr,
		logic [REG_W-1:0] sthr);
		longint          sx, sy, ex, ey, t, at, dx, dy, one;
		longint          minx, maxx, miny, maxy, rcx, rcy, r, px, py, a, b, hi, lo;
		longint unsigned den, len;
		logic            arc, sat, cneg;
		box_t            o;
		sx = s.start_x;
		sy = s.start_y;
		ex = s.end_x;
		ey = s.end_y;
		t = s.bulge;
		at = t < 0 ? -t : t;
		minx = sx < ex ? sx : ex;
		maxx = sx < ex ? ex : sx;
		miny = sy < ey ? sy : ey;
		maxy = sy < ey ? ey : sy;
		arc = (at != 0) && (at >= longint'(lthr));
		sat = 1'b0;
		if (arc) begin
			dx = ex - sx;
			dy = ey - sy;
			one = longint'(1) << BULGE_FRAC;
			den = 4 * at * one;
			if (t > longint'(sthr)) begin
				rcx = div_round(dx, 2);
				rcy = div_round(dy, 2);
			end else begin
				a = 2 * t * one;
				b = one * one - t * t;
				// dividing by 4|t| times one, so a negative bulge flips the numerator
				if (t < 0) begin
					rcx = div_round(-(mul_wide(dx, a) - mul_wide(dy, b)), den);
					rcy = div_round(-(mul_wide(dy, a) + mul_wide(dx, b)), den);
				end else begin
					rcx = div_round(mul_wide(dx, a) - mul_wide(dy, b), den);
					rcy = div_round(mul_wide(dy, a) + mul_wide(dx, b), den);
				end
			end
			len = root_round(mul_wide(dx, dx) + mul_wide(dy, dy));
			r = div_round(mul_wide(longint'(len), one * one + t * t), den);
			cneg = cross_wide(dx, dy, rcx, rcy) < 0;
			for (int k = 0; k < 4; k++) begin
				px = rcx + (k == 0 ? r : (k == 2 ? -r : 0));
				py = rcy + (k == 1 ? r : (k == 3 ? -r : 0));
				// keep extremes on the far side of the chord from the centre
				if ((cross_wide(dx, dy, px, py) < 0) != cneg) begin
					px += sx;
					py += sy;
					if (px < minx) minx = px;
					if (px > maxx) maxx = px;
					if (py < miny) miny = py;
					if (py > maxy) maxy = py;
				end
			end
		end
		hi = (longint'(1) << (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (minx > hi || minx < lo || miny > hi || miny < lo ||
			maxx > hi || maxx < lo || maxy > hi || maxy < lo)
			sat = 1'b1;
		o.min_x = COORD_W'(minx > hi ? hi : (minx < lo ? lo : minx));
		o.min_y = COORD_W'(miny > hi ? hi : (miny < lo ? lo : miny));
		o.max_x = COORD_W'(maxx > hi ? hi : (maxx < lo ? lo : maxx));
		o.max_y = COORD_W'(maxy > hi ? hi : (maxy < lo ? lo : maxy));
		o.is_arc = arc;
		o.saturated = sat;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		box_t want;
		int   pushed, popped;
		if (!arst_n) begin
			line_thr <= LINE_THR_RST;
			semi_thr <= SEMI_THR_RST;
			mismatches <= 0;
			boxes_owed <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			if (seg_valid && !seg_stall) begin
				box_q.push_back(predict_box(seg, line_thr, semi_thr));
				pushed = 1;
			end
			if (box_valid && !box_stall) begin
				if (box_q.size() == 0) begin
					if (mismatches < 10)
						$display("box transaction with nothing owed: %h", box);
					mismatches <= mismatches + 1;
				end else begin
					want = box_q.pop_front();
					popped = 1;
					if (want.min_x !== box.min_x || want.min_y !== box.min_y ||
						want.max_x !== box.max_x || want.max_y !== box.max_y ||
						want.is_arc !== box.is_arc || want.saturated !== box.saturated) begin
						if (mismatches < 10)
							$display("box mismatch: expected %h got %h", want, box);
						mismatches <= mismatches + 1;
					end
				end
			end
			boxes_owed <= boxes_owed + pushed - popped;
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LINE_THR)
					line_thr <= pwdata[REG_W-1:0];
				else
					semi_thr <= pwdata[REG_W-1:0];
			end
		end
	end

endmodule

// ===== sim/bulge_arc_bounding_box_tb.sv =====
// bulge_arc_bounding_box_tb: stimulus and verdict for the bulge arc bounding box block
// directed and random segments over several threshold settings, random idling and stalls
// depends on bab_pkg, bab_box_checker and the block itself
`timescale 1ns / 1ps

module bulge_arc_bounding_box_tb;
	import bab_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_WAIT  = 50;
	localparam int HOLD_CYCLES = 400;
	localparam logic [ADDR_W-1:0] LINE_ADDR = {REG_LINE_THR, 2'b00};
	localparam logic [ADDR_W-1:0] SEMI_ADDR = {REG_SEMI_THR, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               seg_valid;
	logic               seg_stall;
	seg_t               seg;
	logic               box_valid;
	logic               box_stall;
	box_t               box;
	logic               psel, penable, pwrite, pready;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata, prdata;
	int                 mismatches, boxes_owed;
	int                 idle_cycles;
	int                 burst_left;
	int                 segs_sent;
	logic               hold_req;

	bulge_arc_bounding_box u_top (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.box_valid(box_valid), .box_stall(box_stall), .box(box),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bab_box_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
		.box_valid(box_valid), .box_stall(box_stall), .box(box),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .boxes_owed(boxes_owed)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// nothing accepted for too long means the block has hung
	always @(posedge clk) begin
		if ((seg_valid && !seg_stall) || (box_valid && !box_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold when asked
	initial begin
		int period, duty, n;
		box_stall <= 1'b0;
		hold_req <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				box_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end
			period = $urandom_range(1, 12);
			duty = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, period - 1);
			n = 0;
			repeat ($urandom_range(20, 80)) begin
				box_stall <= (n % period) < duty;
				n++;
				@(posedge clk);
			end
		end
	end

	task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_seg(seg_t s);
		int gap;
		seg <= s;
		seg_valid <= 1'b1;
		do @(posedge clk); while (seg_stall);
		segs_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				seg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		seg_valid <= 1'b0;
		@(posedge clk);
		while (boxes_owed != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2, 3: return $signed($urandom_range(0, 2047)) - 1024;
			default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
		endcase
	endfunction

	function automatic logic signed [BULGE_W-1:0] rand_bulge();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = $urandom_range(0, 4);
			2: v = 16384 - $urandom_range(0, 6);
			default: v = $urandom_range(0, 16384);
		endcase
		return BULGE_W'($urandom_range(0, 1) ? -v : v);
	endfunction

	function automatic seg_t rand_seg();
		seg_t s;
		s.start_x = rand_coord();
		s.start_y = rand_coord();
		s.bulge = rand_bulge();
		// a share of chords stay short or axis-aligned
		case ($urandom_range(0, 7))
			0: begin s.end_x = s.start_x; s.end_y = s.start_y; end
			1: begin s.end_x = s.start_x; s.end_y = rand_coord(); end
			2: begin s.end_x = rand_coord(); s.end_y = s.start_y; end
			3: begin
				s.end_x = s.start_x + ($signed($urandom_range(0, 255)) - 128);
				s.end_y = s.start_y + ($signed($urandom_range(0, 255)) - 128);
			end
			default: begin s.end_x = rand_coord(); s.end_y = rand_coord(); end
		endcase
		return s;
	endfunction

	function automatic seg_t mk_seg(int sx, int sy, int ex, int ey, int t);
		seg_t s;
		s.start_x = sx;
		s.start_y = sy;
		s.end_x = ex;
		s.end_y = ey;
		s.bulge = BULGE_W'(t);
		return s;
	endfunction

	initial begin
		int line_set[7] = '{0, 16384, 32767, 0, 200, 1, 0};
		int semi_set[7] = '{16384, 0, 32767, 0, 8000, 16380, 0};
		int p0, p1, p2;
		arst_n = 1'b0;
		seg_valid <= 1'b0;
		seg <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_cycles <= 0;
		segs_sent = 0;
		burst_left = 8;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed segments under reset thresholds
		p0 = 32'sh00010000;
		send_seg(mk_seg(0, 0, p0, 0, 0));
		send_seg(mk_seg(0, 0, p0, 0, 1));
		send_seg(mk_seg(0, 0, p0, 0, -1));
		send_seg(mk_seg(0, 0, p0, p0, 16384));
		send_seg(mk_seg(0, 0, p0, p0, -16384));
		send_seg(mk_seg(0, 0, p0, 0, 16380));
		send_seg(mk_seg(0, 0, p0, 0, 16381));
		send_seg(mk_seg(0, 0, 0, p0, 8192));
		send_seg(mk_seg(0, 0, -p0, 0, -8192));
		send_seg(mk_seg(p0, p0, p0, p0, 8192));
		send_seg(mk_seg(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 8192));
		send_seg(mk_seg(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, -16384));
		send_seg(mk_seg(32'sh80000000, 0, 32'sh7fffffff, 0, 2));
		send_seg(mk_seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16384));
		send_seg(mk_seg(-5, 3, 7, -9, 3));
		send_seg(mk_seg(0, 0, 1, 0, -16384));
		send_seg(mk_seg(100, 200, 300, 400, 16383));
		send_seg(mk_seg(-p0, 0, p0, 0, 12000));
		drain();

		// random segments over a series of threshold settings
		for (int ph = 0; ph < 7; ph++) begin
			p1 = line_set[ph];
			p2 = semi_set[ph];
			if (ph == 6) begin
				p1 = $urandom_range(0, 32767);
				p2 = $urandom_range(0, 32767);
			end
			reg_write(LINE_ADDR, p1);
			reg_write(SEMI_ADDR, p2);
			if (ph == 1)
				hold_req <= 1'b1;
			repeat (130) send_seg(rand_seg());
			drain();
		end

		$display("ran %0d segments through reset, extreme and random threshold settings",
			segs_sent);
		$display("boxes owed at end: %0d, mismatches: %0d", boxes_owed, mismatches);
		if (mismatches == 0 && boxes_owed == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
